>>> rtl/dfhe_pkg.sv
`default_nettype none
package dfhe_pkg;

  localparam int LEN_CODES   = 29;
  localparam int DIST_CODES  = 30;
  localparam int GROUP_W     = 31;
  localparam int COUNT_W     = 5;

  localparam logic [1:0] OP_LITERAL = 2'd0;
  localparam logic [1:0] OP_MATCH   = 2'd1;
  localparam logic [1:0] OP_EOB     = 2'd2;
  localparam logic [1:0] OP_HEADER  = 2'd3;

  localparam logic [8:0]  LEN_MIN  = 9'd3;
  localparam logic [8:0]  LEN_MAX  = 9'd258;
  localparam logic [15:0] DIST_MAX = 16'd32768;

  typedef enum logic [2:0] {
    KIND_LIT,
    KIND_MATCH,
    KIND_EOB,
    KIND_HDR,
    KIND_BAD
  } kind_t;

  // Classified token handed from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  lit;
    logic        fin;
    logic [4:0]  len_idx;
    logic [4:0]  len_ext;
    logic [4:0]  dist_idx;
    logic [12:0] dist_ext;
  } token_t;

  function automatic logic [8:0] len_base(input logic [4:0] idx);
    logic [8:0] r;
    case (idx)
      5'd0:  r = 9'd3;
      5'd1:  r = 9'd4;
      5'd2:  r = 9'd5;
      5'd3:  r = 9'd6;
      5'd4:  r = 9'd7;
      5'd5:  r = 9'd8;
      5'd6:  r = 9'd9;
      5'd7:  r = 9'd10;
      5'd8:  r = 9'd11;
      5'd9:  r = 9'd13;
      5'd10: r = 9'd15;
      5'd11: r = 9'd17;
      5'd12: r = 9'd19;
      5'd13: r = 9'd23;
      5'd14: r = 9'd27;
      5'd15: r = 9'd31;
      5'd16: r = 9'd35;
      5'd17: r = 9'd43;
      5'd18: r = 9'd51;
      5'd19: r = 9'd59;
      5'd20: r = 9'd67;
      5'd21: r = 9'd83;
      5'd22: r = 9'd99;
      5'd23: r = 9'd115;
      5'd24: r = 9'd131;
      5'd25: r = 9'd163;
      5'd26: r = 9'd195;
      5'd27: r = 9'd227;
      5'd28: r = 9'd258;
      default: r = 9'd511;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] len_extra(input logic [4:0] idx);
    logic [2:0] r;
    if (idx < 5'd8 || idx == 5'd28) begin
      r = 3'd0;
    end else begin
      r = 3'(idx[4:2] - 3'd1);
    end
    return r;
  endfunction

  function automatic logic [15:0] dist_base(input logic [4:0] idx);
    logic [15:0] r;
    case (idx)
      5'd0:  r = 16'd1;
      5'd1:  r = 16'd2;
      5'd2:  r = 16'd3;
      5'd3:  r = 16'd4;
      5'd4:  r = 16'd5;
      5'd5:  r = 16'd7;
      5'd6:  r = 16'd9;
      5'd7:  r = 16'd13;
      5'd8:  r = 16'd17;
      5'd9:  r = 16'd25;
      5'd10: r = 16'd33;
      5'd11: r = 16'd49;
      5'd12: r = 16'd65;
      5'd13: r = 16'd97;
      5'd14: r = 16'd129;
      5'd15: r = 16'd193;
      5'd16: r = 16'd257;
      5'd17: r = 16'd385;
      5'd18: r = 16'd513;
      5'd19: r = 16'd769;
      5'd20: r = 16'd1025;
      5'd21: r = 16'd1537;
      5'd22: r = 16'd2049;
      5'd23: r = 16'd3073;
      5'd24: r = 16'd4097;
      5'd25: r = 16'd6145;
      5'd26: r = 16'd8193;
      5'd27: r = 16'd12289;
      5'd28: r = 16'd16385;
      5'd29: r = 16'd24577;
      default: r = 16'hFFFF;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] dist_extra(input logic [4:0] idx);
    logic [3:0] r;
    if (idx < 5'd4) begin
      r = 4'd0;
    end else begin
      r = 4'(idx[4:1] - 4'd1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/dfhe_front.sv
`default_nettype none
module dfhe_front (
  input  wire logic [1:0]   opcode,
  input  wire logic [7:0]   literal_byte,
  input  wire logic [8:0]   match_length,
  input  wire logic [15:0]  match_distance,
  input  wire logic         final_block,
  output dfhe_pkg::token_t  tok
);

  logic [4:0]  li;
  logic [4:0]  di;
  logic        bad;
  logic [8:0]  len_off;
  logic [15:0] dist_off;

  // Find the highest code whose base does not exceed the value.
  always_comb begin
    li = 5'd0;
    for (int i = 1; i < dfhe_pkg::LEN_CODES; i++) begin
      if (match_length >= dfhe_pkg::len_base(5'(i))) li = 5'(i);
    end
    di = 5'd0;
    for (int i = 1; i < dfhe_pkg::DIST_CODES; i++) begin
      if (match_distance >= dfhe_pkg::dist_base(5'(i))) di = 5'(i);
    end
  end

  assign bad = (match_length < dfhe_pkg::LEN_MIN) || (match_length > dfhe_pkg::LEN_MAX) ||
               (match_distance == 16'd0) || (match_distance > dfhe_pkg::DIST_MAX);
  assign len_off  = match_length - dfhe_pkg::len_base(li);
  assign dist_off = match_distance - dfhe_pkg::dist_base(di);

  always_comb begin
    tok.lit      = literal_byte;
    tok.fin      = final_block;
    tok.len_idx  = li;
    tok.len_ext  = len_off[4:0];
    tok.dist_idx = di;
    tok.dist_ext = dist_off[12:0];
    case (opcode)
      dfhe_pkg::OP_LITERAL: tok.kind = dfhe_pkg::KIND_LIT;
      dfhe_pkg::OP_MATCH:   tok.kind = bad ? dfhe_pkg::KIND_BAD : dfhe_pkg::KIND_MATCH;
      dfhe_pkg::OP_EOB:     tok.kind = dfhe_pkg::KIND_EOB;
      dfhe_pkg::OP_HEADER:  tok.kind = dfhe_pkg::KIND_HDR;
      default:              tok.kind = dfhe_pkg::KIND_BAD;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/dfhe_queue.sv
`default_nettype none
module dfhe_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire dfhe_pkg::token_t  push_tok,
  output logic                   not_full,
  input  wire logic              pop,
  output logic                   not_empty,
  output dfhe_pkg::token_t       head_tok
);

  dfhe_pkg::token_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head_tok  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_tok;
  end

endmodule
`default_nettype wire

>>> rtl/dfhe_back.sv
`default_nettype none
module dfhe_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              tok_valid,
  input  wire dfhe_pkg::token_t  tok,
  output logic                   tok_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [30:0]            out_bit_group,
  output logic [4:0]             out_bit_count,
  output logic                   out_bad_input
);

  logic        valid_r, valid_nxt;
  logic [30:0] group_r, group_nxt;
  logic [4:0]  count_r, count_nxt;
  logic        bad_r, bad_nxt;

  logic [8:0]  code;
  logic [3:0]  code_len;
  logic [8:0]  code_rev;
  logic [4:0]  dist_rev;
  logic [2:0]  len_ne;
  logic [3:0]  dist_ne;
  logic [4:0]  sh_len;
  logic [4:0]  sh_dist;
  logic [4:0]  sh_dext;

  // Pick the fixed literal/length code for the head token.
  always_comb begin
    case (tok.kind)
      dfhe_pkg::KIND_LIT: begin
        if (tok.lit < 8'd144) begin
          code     = 9'(9'd48 + {1'b0, tok.lit});
          code_len = 4'd8;
        end else begin
          code     = {1'b1, tok.lit};
          code_len = 4'd9;
        end
      end
      dfhe_pkg::KIND_MATCH: begin
        if (tok.len_idx < 5'd23) begin
          code     = 9'(tok.len_idx + 5'd1);
          code_len = 4'd7;
        end else begin
          code     = 9'({4'd0, tok.len_idx} + 9'd169);
          code_len = 4'd8;
        end
      end
      default: begin
        code     = 9'd0;
        code_len = 4'd7;
      end
    endcase
  end

  // Huffman codes go out MSB first: reverse, then right-align.
  always_comb begin
    for (int j = 0; j < 9; j++) code_rev[j] = code[8 - j];
    code_rev = code_rev >> (4'd9 - code_len);
    for (int j = 0; j < 5; j++) dist_rev[j] = tok.dist_idx[4 - j];
  end

  assign len_ne  = dfhe_pkg::len_extra(tok.len_idx);
  assign dist_ne = dfhe_pkg::dist_extra(tok.dist_idx);
  assign sh_len  = {1'b0, code_len};
  assign sh_dist = 5'(sh_len + {2'b0, len_ne});
  assign sh_dext = 5'(sh_dist + 5'd5);

  always_comb begin
    bad_nxt = 1'b0;
    case (tok.kind)
      dfhe_pkg::KIND_LIT: begin
        group_nxt = {22'd0, code_rev};
        count_nxt = sh_len;
      end
      dfhe_pkg::KIND_MATCH: begin
        group_nxt = {22'd0, code_rev}
                  | ({26'd0, tok.len_ext} << sh_len)
                  | ({26'd0, dist_rev} << sh_dist)
                  | ({18'd0, tok.dist_ext} << sh_dext);
        count_nxt = 5'(sh_dext + {1'b0, dist_ne});
      end
      dfhe_pkg::KIND_EOB: begin
        group_nxt = 31'd0;
        count_nxt = 5'd7;
      end
      dfhe_pkg::KIND_HDR: begin
        group_nxt = {29'd0, 1'b1, tok.fin};
        count_nxt = 5'd3;
      end
      default: begin
        group_nxt = 31'd0;
        count_nxt = 5'd0;
        bad_nxt   = 1'b1;
      end
    endcase
  end

  assign tok_pop = tok_valid && (!valid_r || out_ready);

  always_comb begin
    if (tok_pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      group_r <= group_nxt;
      count_r <= count_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_bit_group = group_r;
  assign out_bit_count = count_r;
  assign out_bad_input = bad_r;

endmodule
`default_nettype wire

>>> rtl/deflate_fixed_huffman_symbol_encoder_unit.sv
// Fixed-Huffman token encoder for DEFLATE block type 1.
// Input channel (in_valid/in_ready): one token per transfer - literal byte,
// length/distance match, end of block or block header (BFINAL + BTYPE 01).
// Output channel (out_valid/out_ready): one result per token, in order:
// out_bit_group holds the bits to append with bit 0 sent first,
// out_bit_count the number of valid bits (0..31), out_bad_input flags a
// match whose length or distance is out of range (then no bits are given).
// A transferred token is written into the queue and from there registered
// in the output register when nothing is waiting ahead of it.
// Throughput: one token per cycle while out_ready is high; the front end
// classifies the token (length/distance code search) in the cycle of its
// transfer, the back end builds the bit group and registers it.
// A two-entry queue sits between them. When the receiver stalls, the output
// register holds its result, the queue fills, and in_ready drops once both
// entries are taken; it rises again as soon as one result transfers.
// Reset (rst_n low at a clock edge) empties the queue and drops out_valid.
`default_nettype none
module deflate_fixed_huffman_symbol_encoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_literal_byte,
  input  wire logic [8:0]  in_match_length,
  input  wire logic [15:0] in_match_distance,
  input  wire logic        in_final_block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [30:0]      out_bit_group,
  output logic [4:0]       out_bit_count,
  output logic             out_bad_input
);

  dfhe_pkg::token_t in_tok;
  dfhe_pkg::token_t head_tok;
  logic             q_not_full;
  logic             q_not_empty;
  logic             q_pop;
  logic             q_push;

  // Classify the incoming token.
  dfhe_front u_front (
    .opcode         (in_opcode),
    .literal_byte   (in_literal_byte),
    .match_length   (in_match_length),
    .match_distance (in_match_distance),
    .final_block    (in_final_block),
    .tok            (in_tok)
  );

  assign in_ready = q_not_full;
  assign q_push   = in_valid && q_not_full;

  // Decouple front and back so each can stall on its own.
  dfhe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (in_tok),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  // Build the bit group and hold it until the receiver takes it.
  dfhe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .tok_valid     (q_not_empty),
    .tok           (head_tok),
    .tok_pop       (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bit_group (out_bit_group),
    .out_bit_count (out_bit_count),
    .out_bad_input (out_bad_input)
  );

endmodule
`default_nettype wire
